[hdl/token_stream_lexer_unit_defines.svh]
// assertion macros shared by the lexer checker
// no dependencies; included by files that assert
`ifndef TOKEN_STREAM_LEXER_UNIT_DEFINES_SVH
`define TOKEN_STREAM_LEXER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tsl_pkg.sv]
// types and constants of the token stream lexer
// no dependencies; imported by every lexer module
`default_nettype none

package tsl_pkg;

    localparam int START_W     = 24;
    localparam int LEN_W       = 8;
    localparam int CHAR_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int KW_LEN      = 6;

    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7b;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7d;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5f;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;

    typedef enum logic [3:0] {
        KIND_IDENT  = 4'd0,
        KIND_INT    = 4'd1,
        KIND_RETURN = 4'd2,
        KIND_LPAREN = 4'd3,
        KIND_RPAREN = 4'd4,
        KIND_LBRACE = 4'd5,
        KIND_RBRACE = 4'd6,
        KIND_SEMI   = 4'd7,
        KIND_ERROR  = 4'd8,
        KIND_END    = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_INT   = 2'd2,
        MODE_ERROR = 2'd3
    } mode_t;

    typedef struct packed {
        kind_t              kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic [CHAR_W-1:0]  bad;
        logic               overlong;
        logic               last;
    } token_t;

    // up to two words per accepted byte, packed from the front
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    function automatic logic [CHAR_W-1:0] kw_char(input logic [2:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            3'd0:    c = 8'h72;
            3'd1:    c = 8'h65;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h75;
            3'd4:    c = 8'h72;
            3'd5:    c = 8'h6e;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/tsl_front.sv]
// lexer front: classifies each byte, keeps the scan state, builds token words
// depends on tsl_pkg
`default_nettype none

module tsl_front #(
    parameter int POSITION_BITS = 24,
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tsl_pkg::CHAR_W-1:0]  ch,
    input  logic                        end_marker,
    input  logic                        accept,
    output tsl_pkg::push_t              push
);
    import tsl_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [LEN_W-1:0] KW_LEN_V = LEN_W'(KW_LEN);

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic                     kp_reg, kp_next;
    logic                     ov_reg, ov_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic  is_letter, is_digit, is_word, is_space, is_mark, is_bad;
    kind_t mark_kind;
    logic  pending, extend;

    token_t tok_a, tok_b;
    logic   a_v, b_v;

    // byte classes
    always_comb
    begin
        is_letter = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a);
        is_digit  = (ch >= 8'h30 && ch <= 8'h39);
        is_word   = is_letter || (ch == CH_UNDER);
        is_space  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        is_mark   = 1'b1;
        unique case (ch)
            CH_LPAREN: mark_kind = KIND_LPAREN;
            CH_RPAREN: mark_kind = KIND_RPAREN;
            CH_LBRACE: mark_kind = KIND_LBRACE;
            CH_RBRACE: mark_kind = KIND_RBRACE;
            CH_SEMI:   mark_kind = KIND_SEMI;
            default:
            begin
                mark_kind = KIND_ERROR;
                is_mark   = 1'b0;
            end
        endcase
        is_bad  = !is_word && !is_digit && !is_mark && !is_space;
        pending = (mode_reg == MODE_IDENT) || (mode_reg == MODE_INT);
        extend  = ((mode_reg == MODE_IDENT) && (is_word || is_digit))
                || ((mode_reg == MODE_INT) && is_digit);
    end

    // next scan state
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        kp_next    = kp_reg;
        ov_next    = ov_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            if (end_marker)
            begin
                mode_next  = MODE_IDLE;
                start_next = '0;
                len_next   = '0;
                kp_next    = 1'b0;
                ov_next    = 1'b0;
                pos_next   = '0;
            end
            else
            begin
                pos_next = pos_reg + POSITION_BITS'(1);
                if (mode_reg != MODE_ERROR)
                begin
                    if (extend)
                    begin
                        kp_next = kp_reg && (len_reg < KW_LEN_V)
                                && (ch == kw_char(len_reg[2:0]));
                        if (len_reg < MAX_LEN)
                            len_next = len_reg + LEN_W'(1);
                        else
                            ov_next = 1'b1;
                    end
                    else
                    begin
                        // close whatever is pending, then look at the new byte
                        mode_next = MODE_IDLE;
                        len_next  = '0;
                        kp_next   = 1'b0;
                        ov_next   = 1'b0;
                        if (is_word || is_digit)
                        begin
                            mode_next  = is_word ? MODE_IDENT : MODE_INT;
                            start_next = pos_reg;
                            len_next   = LEN_W'(1);
                            kp_next    = is_word && (ch == kw_char(3'd0));
                        end
                        else if (is_bad)
                            mode_next = MODE_ERROR;
                    end
                end
            end
        end
    end

    // token words for this byte
    always_comb
    begin
        tok_a.kind     = KIND_INT;
        if (mode_reg == MODE_IDENT)
            tok_a.kind = (kp_reg && (len_reg == KW_LEN_V) && !ov_reg) ? KIND_RETURN
                                                                      : KIND_IDENT;
        tok_a.start    = START_W'(start_reg);
        tok_a.length   = len_reg;
        tok_a.bad      = '0;
        tok_a.overlong = ov_reg;

        tok_b.start    = START_W'(pos_reg);
        tok_b.overlong = 1'b0;
        tok_b.last     = 1'b1;
        if (end_marker)
        begin
            tok_b.kind   = KIND_END;
            tok_b.length = '0;
            tok_b.bad    = '0;
            a_v          = pending;
            b_v          = 1'b1;
        end
        else
        begin
            tok_b.kind   = is_mark ? mark_kind : KIND_ERROR;
            tok_b.length = LEN_W'(1);
            tok_b.bad    = is_mark ? '0 : ch;
            a_v          = (mode_reg != MODE_ERROR) && !extend && pending;
            b_v          = (mode_reg != MODE_ERROR) && !extend && (is_mark || is_bad);
        end
        tok_a.last = !b_v;

        push.count  = accept ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
        push.first  = a_v ? tok_a : tok_b;
        push.second = tok_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            kp_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            kp_reg    <= kp_next;
            ov_reg    <= ov_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

[hdl/tsl_queue.sv]
// lexer back end: short token queue taking up to two words a cycle,
// giving one while out_ready is high; depends on tsl_pkg
`default_nettype none

module tsl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  tsl_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output tsl_pkg::token_t  head
);
    import tsl_pkg::*;

    token_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = entry_reg[rd_ptr_reg];
    // a byte may bring two words
    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_reg + QPTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/token_stream_lexer_unit.sv]
// top level of the token stream lexer: front classifier and token queue
// depends on tsl_pkg, tsl_front, tsl_queue
//
// channel   direction  handshake             payload
// input     in         in_valid / in_ready   ch, end_marker
// output    out        out_valid / out_ready kind, start_res, length, bad_char, overlong, last
//
// one byte is taken per cycle while in_ready is high; its words are written into the queue as it is taken
// a byte that closes a token and is itself a mark, an error or the end marker yields two words,
// drained at one word per cycle while out_ready is high, through the four-entry queue
// in_ready is high while the queue holds two words or fewer
// reset clears the scan state, byte position and queue at once
`default_nettype none

module token_stream_lexer_unit #(
    parameter int POSITION_BITS = 24,
    parameter int MAX_TOKEN_LEN = 255
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tsl_pkg::CHAR_W-1:0]   ch,
    input  logic                         end_marker,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [3:0]                   kind,
    output logic [tsl_pkg::START_W-1:0]  start_res,
    output logic [tsl_pkg::LEN_W-1:0]    length,
    output logic [tsl_pkg::CHAR_W-1:0]   bad_char,
    output logic                         overlong,
    output logic                         last
);
    import tsl_pkg::*;

    push_t  push;
    token_t head;
    logic   room;
    logic   accept;

    assign in_ready = room;
    assign accept   = in_valid && room;

    tsl_front #(
        .POSITION_BITS (POSITION_BITS),
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ch         (ch),
        .end_marker (end_marker),
        .accept     (accept),
        .push       (push)
    );

    tsl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind      = head.kind;
    assign start_res = head.start;
    assign length    = head.length;
    assign bad_char  = head.bad;
    assign overlong  = head.overlong;
    assign last      = head.last;

endmodule

`default_nettype wire

[hdl/tsl_checker.sv]
// port-level checks of the token stream lexer, bound to the top level
// depends on tsl_pkg and token_stream_lexer_unit_defines.svh
`default_nettype none

`include "token_stream_lexer_unit_defines.svh"

module tsl_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [tsl_pkg::CHAR_W-1:0]   ch,
    input  logic                         end_marker,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [3:0]                   kind,
    input  logic [tsl_pkg::START_W-1:0]  start_res,
    input  logic [tsl_pkg::LEN_W-1:0]    length,
    input  logic [tsl_pkg::CHAR_W-1:0]   bad_char,
    input  logic                         overlong,
    input  logic                         last
);
    import tsl_pkg::*;

    logic                                  stalled;
    logic                                  in_waiting;
    logic                                  end_word;
    logic                                  err_word;
    logic                                  plain_word;
    logic [CHAR_W:0]                       in_word;
    logic [4+START_W+LEN_W+CHAR_W+1:0]     out_word;

    assign stalled    = out_valid && !out_ready;
    assign in_waiting = in_valid && !in_ready;
    assign end_word   = out_valid && (kind == KIND_END);
    assign err_word   = out_valid && (kind == KIND_ERROR);
    assign plain_word = out_valid && (kind != KIND_ERROR);
    assign in_word    = {ch, end_marker};
    assign out_word   = {kind, start_res, length, bad_char, overlong, last};

    `TSL_ASSERT_NXT(a_in_hold, clk, rst_n, in_waiting, in_valid && $stable(in_word), "input not held")
    `TSL_ASSERT_NXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(out_word), "output not held")
    `TSL_ASSERT_IMP(a_end_last, clk, rst_n, end_word, last && (length == '0) && !overlong, "bad end word")
    `TSL_ASSERT_IMP(a_err_word, clk, rst_n, err_word, last && (length == LEN_W'(1)), "bad error word")
    `TSL_ASSERT_IMP(a_bad_zero, clk, rst_n, plain_word, bad_char == '0, "bad_char on non-error word")

endmodule

bind token_stream_lexer_unit tsl_checker u_tsl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .end_marker (end_marker),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .start_res  (start_res),
    .length     (length),
    .bad_char   (bad_char),
    .overlong   (overlong),
    .last       (last)
);

`default_nettype wire

[dv/tb_token_stream_lexer_unit.sv]
// self-checking testbench of token_stream_lexer_unit: directed and random byte streams
// a scoreboard class predicts every token word and checks it on the output channel
// depends on tsl_pkg and token_stream_lexer_unit
`timescale 1ns / 1ps

module tb_token_stream_lexer_unit;

    import tsl_pkg::*;

    localparam int    MAX_LEN     = 255;
    localparam int    CYCLE_LIMIT = 200000;
    localparam string KEYWORD     = "return";

    class token_scoreboard;
        token_t             pending_tokens[$];
        mode_t              mode;
        logic [START_W-1:0] tok_start;
        int unsigned        tok_len;
        bit                 kw_ok;
        bit                 over;
        logic [START_W-1:0] pos;
        int unsigned        errors;

        function new();
            clear_scan();
            errors = 0;
        endfunction

        function void clear_scan();
            mode      = MODE_IDLE;
            tok_start = '0;
            tok_len   = 0;
            kw_ok     = 1'b0;
            over      = 1'b0;
            pos       = '0;
        endfunction

        function void note_token(kind_t k, logic [START_W-1:0] s, int unsigned len,
                                 logic [CHAR_W-1:0] bad, bit ov);
            token_t t;
            t.kind     = k;
            t.start    = s;
            t.length   = LEN_W'(len);
            t.bad      = bad;
            t.overlong = ov;
            t.last     = 1'b0;
            pending_tokens.push_back(t);
        endfunction

        function void close_pending();
            kind_t k;
            if (mode == MODE_IDENT)
                k = (kw_ok && tok_len == KW_LEN && !over) ? KIND_RETURN : KIND_IDENT;
            else if (mode == MODE_INT)
                k = KIND_INT;
            else
                return;
            note_token(k, tok_start, tok_len, '0, over);
            mode    = MODE_IDLE;
            tok_len = 0;
            kw_ok   = 1'b0;
            over    = 1'b0;
        endfunction

        // works out the words one accepted byte gives
        function void scan_byte(logic [CHAR_W-1:0] c, bit endm);
            int    queued_at_entry;
            bit    word_c;
            bit    digit_c;
            bit    is_mark;
            kind_t mk;
            queued_at_entry = pending_tokens.size();
            if (endm)
            begin
                close_pending();
                note_token(KIND_END, pos, 0, '0, 1'b0);
                clear_scan();
            end
            else
            begin
                if (mode != MODE_ERROR)
                begin
                    word_c  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
                    digit_c = c >= "0" && c <= "9";
                    if ((mode == MODE_IDENT && (word_c || digit_c)) ||
                        (mode == MODE_INT && digit_c))
                    begin
                        kw_ok = kw_ok && tok_len < KW_LEN && c == KEYWORD[tok_len];
                        if (tok_len < MAX_LEN)
                            tok_len++;
                        else
                            over = 1'b1;
                    end
                    else
                    begin
                        close_pending();
                        is_mark = 1'b1;
                        mk      = KIND_ERROR;
                        case (c)
                            CH_LPAREN: mk = KIND_LPAREN;
                            CH_RPAREN: mk = KIND_RPAREN;
                            CH_LBRACE: mk = KIND_LBRACE;
                            CH_RBRACE: mk = KIND_RBRACE;
                            CH_SEMI:   mk = KIND_SEMI;
                            default:   is_mark = 1'b0;
                        endcase
                        if (word_c || digit_c)
                        begin
                            mode      = word_c ? MODE_IDENT : MODE_INT;
                            tok_start = pos;
                            tok_len   = 1;
                            kw_ok     = word_c && c == KEYWORD[0];
                            over      = 1'b0;
                        end
                        else if (is_mark)
                            note_token(mk, pos, 1, '0, 1'b0);
                        else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
                        begin
                            note_token(KIND_ERROR, pos, 1, c, 1'b0);
                            mode = MODE_ERROR;
                        end
                    end
                end
                // position moves on in error mode too
                pos = pos + 1'b1;
            end
            if (pending_tokens.size() > queued_at_entry)
                pending_tokens[pending_tokens.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 100)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task match_token(token_t got);
            token_t want;
            if (pending_tokens.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word kind %0d start %0d",
                                          got.kind, got.start));
                return;
            end
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d (start %0d)",
                                          got.kind, want.kind, want.start));
            if (got.start !== want.start)
                report_mismatch($sformatf("start_res %0d, want %0d", got.start, want.start));
            if (got.length !== want.length)
                report_mismatch($sformatf("length %0d, want %0d (start %0d)",
                                          got.length, want.length, want.start));
            if (got.bad !== want.bad)
                report_mismatch($sformatf("bad_char %0h, want %0h (start %0d)",
                                          got.bad, want.bad, want.start));
            if (got.overlong !== want.overlong)
                report_mismatch($sformatf("overlong %0b, want %0b (start %0d)",
                                          got.overlong, want.overlong, want.start));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b (start %0d)",
                                          got.last, want.last, want.start));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [CHAR_W-1:0]  ch;
    logic               end_marker;
    logic               out_valid;
    logic               out_ready;
    logic [3:0]         kind;
    logic [START_W-1:0] start_res;
    logic [LEN_W-1:0]   length;
    logic [CHAR_W-1:0]  bad_char;
    logic               overlong;
    logic               last;

    token_scoreboard sb = new();
    bit              gap_on;
    bit              stall_on;
    int unsigned     bytes_scanned;

    token_stream_lexer_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .end_marker (end_marker),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .start_res  (start_res),
        .length     (length),
        .bad_char   (bad_char),
        .overlong   (overlong),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= stall_on ? ($urandom_range(99) >= 29) : 1'b1;
    end

    // words leaving are checked before the byte accepted at the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.match_token(token_t'{kind_t'(kind), start_res, length, bad_char,
                                        overlong, last});
            if (in_valid && in_ready)
                sb.scan_byte(ch, end_marker);
        end
    end

    function automatic logic [CHAR_W-1:0] ident_char(bit lead);
        int unsigned r;
        r = $urandom_range(lead ? 52 : 62, 0);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return CH_UNDER;
        return 8'("0" + r - 53);
    endfunction

    task automatic send_word(logic [CHAR_W-1:0] c, bit endm, bit counts = 1'b1);
        if (gap_on && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        ch         <= c;
        end_marker <= endm;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (counts)
            bytes_scanned++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic send_run(int n, bit digits);
        for (int i = 0; i < n; i++)
            send_word(digits ? 8'("0" + $urandom_range(9)) : ident_char(i == 0), 1'b0);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random_token();
        int unsigned r;
        int unsigned sel;
        r = $urandom_range(99);
        sel = $urandom_range(5);
        if (r < 10)
            send_text(KEYWORD);
        else if (r < 16)
        begin
            // near misses of the keyword
            case (sel % 4)
                0: send_text("retur");
                1: send_text("returnn");
                2: send_text("Return");
                default: send_text("retuRn");
            endcase
        end
        else if (r < 40)
            send_run($urandom_range(10, 1), 1'b0);
        else if (r < 56)
            send_run($urandom_range(8, 1), 1'b1);
        else if (r < 72)
        begin
            case (sel % 5)
                0: send_word(CH_LPAREN, 1'b0);
                1: send_word(CH_RPAREN, 1'b0);
                2: send_word(CH_LBRACE, 1'b0);
                3: send_word(CH_RBRACE, 1'b0);
                default: send_word(CH_SEMI, 1'b0);
            endcase
        end
        else if (r < 84)
            send_word(sel == 5 ? CH_SPACE : 8'(CH_TAB + sel), 1'b0);
        else if (r < 92)
            send_word(8'($urandom), 1'b1);
        else
        begin
            // any byte, then junk that an error leaves ignored, then end of input
            send_word(8'($urandom), 1'b0);
            repeat ($urandom_range(4)) send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        ch         = '0;
        end_marker = 1'b0;
        out_ready  = 1'b0;
        gap_on     = 1'b1;
        stall_on   = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("(return)");
        send_text("9a_{;");
        for (int c = CH_TAB; c <= CH_CR; c++)
            send_word(8'(c), 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_text("Z0}");
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h5a, 1'b1);
        send_text("ab");
        send_word(8'h80, 1'b0);
        send_word(8'h00, 1'b1);
        send_text("7");
        send_word(8'hff, 1'b1);

        while (bytes_scanned < 500)
            send_random_token();

        // hold the sender until every word is out, then run flat out
        wait_for_drain();
        gap_on   = 1'b0;
        stall_on = 1'b0;
        send_run(MAX_LEN, 1'b0);
        send_word(CH_SEMI, 1'b0);
        send_run(MAX_LEN + 2, 1'b1);
        send_word(CH_LPAREN, 1'b0);
        while (bytes_scanned < 1150)
            send_random_token();

        gap_on   = 1'b1;
        stall_on = 1'b1;
        while (bytes_scanned < 1450)
            send_random_token();
        send_word(8'($urandom), 1'b1);

        wait_for_drain();
        if (sb.pending_tokens.size() != 0)
            sb.report_mismatch($sformatf("%0d words never arrived", sb.pending_tokens.size()));
        if (sb.errors == 0)
            $display("tb_token_stream_lexer_unit passed");
        else
            $display("tb_token_stream_lexer_unit failed");
        $finish;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_token_stream_lexer_unit failed");
        $finish;
    end

endmodule
